/* design/dlrq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Doubly linked request queue package
// Shared widths, codes and state types for the request queue design.
// ----------------------------------------------------------------------------
package dlrq_pkg;

  // Number of tags that the link stores hold.
  localparam int TagCount = 256;
  // Width of a link entry and of a store address.
  localparam int IdxW     = $clog2(TagCount);
  // Fixed field widths of the request and response items.
  localparam int OpW      = 3;
  localparam int TagW     = 8;
  localparam int CntW     = 9;

  typedef enum logic [OpW-1:0] {
    OpInsertTail = 3'd0,
    OpInsertHead = 3'd1,
    OpRemove     = 3'd2,
    OpPop        = 3'd3,
    OpPeek       = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StWork = 2'b10
  } state_e;

endpackage
`default_nettype wire

/* design/dlrq_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Request queue channel interfaces
// Valid/ready channels for requests into the queue and responses out of it.
// ----------------------------------------------------------------------------
interface dlrq_req_if;
  logic                      valid;
  logic                      ready;
  logic [dlrq_pkg::OpW-1:0]  operation;
  logic [dlrq_pkg::TagW-1:0] request_tag;

  modport source (output valid, output operation, output request_tag, input ready);
  modport sink   (input valid, input operation, input request_tag, output ready);
endinterface

interface dlrq_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [dlrq_pkg::TagW-1:0] out_tag;
  logic                      tag_valid;
  logic                      error;
  logic [dlrq_pkg::CntW-1:0] queue_count;
  logic [dlrq_pkg::CntW-1:0] high_water;

  modport source (output valid, output out_tag, output tag_valid, output error,
                  output queue_count, output high_water, input ready);
  modport sink   (input valid, input out_tag, input tag_valid, input error,
                  input queue_count, input high_water, output ready);
endinterface
`default_nettype wire

/* design/dlrq_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, with the read data registered.
// ----------------------------------------------------------------------------
module dlrq_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

/* design/doubly_linked_request_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Doubly linked request queue
// Queue of request tags kept as a doubly linked list in two link memories.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Fields                                          Transfer when
//  req_i    in   operation, request_tag                          valid & ready
//  rsp_o    out  out_tag, tag_valid, error, queue_count, high_water  valid & ready
//
// Every request passes through the accept cycle and a work cycle; a new
// request is taken only in the idle state, after the last one is done. The
// registered read of the link memories sets this, since a removal must read the
// links of the removed tag before it can rewrite its neighbors' links.
// Reset clears head, tail, count, high-water mark and all membership flags;
// the link memories are not cleared, as an entry is only read after it has
// been written by an insert. If a response is still waiting, the work cycle
// stretches until the response register can take the new result.
// ----------------------------------------------------------------------------
module doubly_linked_request_queue (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  dlrq_req_if.sink   req_i,
  dlrq_rsp_if.source rsp_o
);

  // Control state.
  dlrq_pkg::state_e state_q, state_d;
  logic [dlrq_pkg::IdxW-1:0] head_q, head_d;
  logic [dlrq_pkg::IdxW-1:0] tail_q, tail_d;
  logic [dlrq_pkg::CntW-1:0] cnt_q, cnt_d;
  logic [dlrq_pkg::CntW-1:0] max_q, max_d;
  logic [dlrq_pkg::TagCount-1:0] member_q, member_d;

  // Request held over the work cycle. The target tag is the popped head for
  // a pop. The ok flag says whether the request changes the queue.
  dlrq_pkg::op_e op_q, op_d;
  logic [dlrq_pkg::IdxW-1:0] tag_q, tag_d;
  logic ok_q, ok_d;

  // Response register.
  logic rsp_valid_q, rsp_valid_d;
  logic [dlrq_pkg::TagW-1:0] rsp_tag_q, rsp_tag_d;
  logic rsp_tvld_q, rsp_tvld_d;
  logic rsp_err_q, rsp_err_d;
  logic [dlrq_pkg::CntW-1:0] rsp_cnt_q;
  logic [dlrq_pkg::CntW-1:0] rsp_hw_q;

  // Link memory ports.
  logic                      next_we, prev_we, link_re;
  logic [dlrq_pkg::IdxW-1:0] next_waddr, prev_waddr, link_raddr;
  logic [dlrq_pkg::IdxW-1:0] next_wdata, prev_wdata;
  logic [dlrq_pkg::IdxW-1:0] next_rdata, prev_rdata;

  logic                      accept, finish;
  dlrq_pkg::op_e             req_op;
  logic [dlrq_pkg::IdxW-1:0] req_idx;
  logic                      in_range, queued;

  assign req_op   = dlrq_pkg::op_e'(req_i.operation);
  assign req_idx  = req_i.request_tag[dlrq_pkg::IdxW-1:0];
  assign in_range = 32'(req_i.request_tag) < dlrq_pkg::TagCount;
  assign queued   = in_range && member_q[req_idx];

  assign req_i.ready = (state_q == dlrq_pkg::StIdle);
  assign accept      = req_i.valid && (state_q == dlrq_pkg::StIdle);
  // The work cycle completes once the response register is free or draining.
  assign finish      = (state_q == dlrq_pkg::StWork) && (!rsp_valid_q || rsp_o.ready);

  // In the accept cycle an insert writes the new tag's own links and a
  // removal or pop reads the target's links. In the work cycle the
  // neighbors' links are written. The two phases never overlap, so a read
  // always sees the writes of the previous request.
  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    tail_d     = tail_q;
    cnt_d      = cnt_q;
    max_d      = max_q;
    member_d   = member_q;
    op_d       = op_q;
    tag_d      = tag_q;
    ok_d       = ok_q;
    next_we    = 1'b0;
    next_waddr = '0;
    next_wdata = '0;
    prev_we    = 1'b0;
    prev_waddr = '0;
    prev_wdata = '0;
    link_re    = 1'b0;
    link_raddr = '0;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    rsp_tag_d  = rsp_tag_q;
    rsp_tvld_d = rsp_tvld_q;
    rsp_err_d  = rsp_err_q;

    if (accept) begin
      state_d = dlrq_pkg::StWork;
      op_d    = req_op;
      tag_d   = req_idx;
      unique case (req_op)
        dlrq_pkg::OpInsertTail: begin
          ok_d       = in_range && !queued;
          next_we    = ok_d;
          next_waddr = req_idx;
          next_wdata = '0;
          prev_we    = ok_d;
          prev_waddr = req_idx;
          prev_wdata = tail_q;
        end
        dlrq_pkg::OpInsertHead: begin
          ok_d       = in_range && !queued;
          next_we    = ok_d;
          next_waddr = req_idx;
          next_wdata = head_q;
          prev_we    = ok_d;
          prev_waddr = req_idx;
          prev_wdata = '0;
        end
        dlrq_pkg::OpRemove: begin
          ok_d       = queued;
          link_re    = 1'b1;
          link_raddr = req_idx;
        end
        dlrq_pkg::OpPop: begin
          ok_d       = (cnt_q != '0);
          tag_d      = head_q;
          link_re    = 1'b1;
          link_raddr = head_q;
        end
        default: begin
          ok_d = 1'b0;
        end
      endcase
    end

    if (finish) begin
      state_d = dlrq_pkg::StIdle;
      unique case (op_q)
        dlrq_pkg::OpInsertTail: begin
          if (ok_q) begin
            if (cnt_q != '0) begin
              next_we    = 1'b1;
              next_waddr = tail_q;
              next_wdata = tag_q;
            end else begin
              head_d = tag_q;
            end
            tail_d          = tag_q;
            member_d[tag_q] = 1'b1;
            cnt_d           = cnt_q + dlrq_pkg::CntW'(1);
          end
        end
        dlrq_pkg::OpInsertHead: begin
          if (ok_q) begin
            if (cnt_q != '0) begin
              prev_we    = 1'b1;
              prev_waddr = head_q;
              prev_wdata = tag_q;
            end else begin
              tail_d = tag_q;
            end
            head_d          = tag_q;
            member_d[tag_q] = 1'b1;
            cnt_d           = cnt_q + dlrq_pkg::CntW'(1);
          end
        end
        dlrq_pkg::OpRemove, dlrq_pkg::OpPop: begin
          if (ok_q) begin
            // Splice the tag out: its successor points back to its
            // predecessor and the other way around.
            if (tag_q == tail_q) begin
              tail_d = prev_rdata;
            end else begin
              prev_we    = 1'b1;
              prev_waddr = next_rdata;
              prev_wdata = prev_rdata;
            end
            if (tag_q == head_q) begin
              head_d = next_rdata;
            end else begin
              next_we    = 1'b1;
              next_waddr = prev_rdata;
              next_wdata = next_rdata;
            end
            member_d[tag_q] = 1'b0;
            cnt_d           = cnt_q - dlrq_pkg::CntW'(1);
            if (cnt_d == '0) begin
              head_d = '0;
              tail_d = '0;
            end
          end
        end
        default: begin
        end
      endcase

      if (cnt_d > max_q) begin
        max_d = cnt_d;
      end

      rsp_valid_d = 1'b1;
      rsp_err_d   = !ok_q && (op_q == dlrq_pkg::OpInsertTail ||
                              op_q == dlrq_pkg::OpInsertHead ||
                              op_q == dlrq_pkg::OpRemove);
      if (op_q == dlrq_pkg::OpPop) begin
        rsp_tvld_d = ok_q;
        rsp_tag_d  = ok_q ? dlrq_pkg::TagW'(tag_q) : '0;
      end else begin
        rsp_tvld_d = (cnt_d != '0);
        rsp_tag_d  = (cnt_d != '0) ? dlrq_pkg::TagW'(head_d) : '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dlrq_pkg::StIdle;
      head_q      <= '0;
      tail_q      <= '0;
      cnt_q       <= '0;
      max_q       <= '0;
      member_q    <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      cnt_q       <= cnt_d;
      max_q       <= max_d;
      member_q    <= member_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    tag_q      <= tag_d;
    ok_q       <= ok_d;
    rsp_tag_q  <= rsp_tag_d;
    rsp_tvld_q <= rsp_tvld_d;
    rsp_err_q  <= rsp_err_d;
    if (finish) begin
      rsp_cnt_q <= cnt_d;
      rsp_hw_q  <= max_d;
    end
  end

  dlrq_ram #(
    .Width (dlrq_pkg::IdxW),
    .Depth (dlrq_pkg::TagCount)
  ) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (next_we),
    .waddr_i (next_waddr),
    .wdata_i (next_wdata),
    .re_i    (link_re),
    .raddr_i (link_raddr),
    .rdata_o (next_rdata)
  );

  dlrq_ram #(
    .Width (dlrq_pkg::IdxW),
    .Depth (dlrq_pkg::TagCount)
  ) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (prev_we),
    .waddr_i (prev_waddr),
    .wdata_i (prev_wdata),
    .re_i    (link_re),
    .raddr_i (link_raddr),
    .rdata_o (prev_rdata)
  );

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.out_tag     = rsp_tag_q;
  assign rsp_o.tag_valid   = rsp_tvld_q;
  assign rsp_o.error       = rsp_err_q;
  assign rsp_o.queue_count = rsp_cnt_q;
  assign rsp_o.high_water  = rsp_hw_q;

endmodule
`default_nettype wire

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Doubly linked request queue testbench
// Sends insert, remove, pop and peek requests with random gaps on both
// channels and checks every response against the list model or a typed result.
// ----------------------------------------------------------------------------
module testbench;
  import dlrq_pkg::*;

  // Operation codes above peek are not decoded by the block and behave as a
  // peek. They are named here so that the stimulus can use them by name.
  localparam logic [OpW-1:0] OpSpare5 = 3'd5;
  localparam logic [OpW-1:0] OpSpare6 = 3'd6;
  localparam logic [OpW-1:0] OpSpare7 = 3'd7;

  // Longest idle stretch that either side inserts before a transfer.
  localparam int MaxWait        = 17;
  // Quiet cycles after the last response, to catch anything left over.
  localparam int DrainCycles    = 16;
  // Number of random requests that follow the directed rows.
  localparam int RandomRequests = 1700;
  // At this point of the random part the queue is filled to the brim once.
  localparam int FillPoint      = 600;
  // Random bias of the request mix is redrawn after this many requests.
  localparam int BiasSpan       = 150;
  // Printing stops after this many mismatches; counting does not.
  localparam int PrintLimit     = 40;

  // One response as the block presents it on the response channel.
  typedef struct packed {
    logic [TagW-1:0] tag;
    logic            tag_valid;
    logic            error;
    logic [CntW-1:0] count;
    logic [CntW-1:0] high_water;
  } queue_result_t;

  // One directed request. Where has_result is set, the response is typed in
  // below; otherwise it comes from the queue model.
  typedef struct packed {
    logic [OpW-1:0]  op;
    logic [TagW-1:0] tag;
    logic            has_result;
    queue_result_t   result;
  } stim_row_t;

  // The rows start from an empty queue right after reset. Comments give the
  // order of the queue from head to tail after each row.
  localparam stim_row_t DirectedRows [24] = '{
    // Empty queue: peek, pop and a removal that finds nothing.
    '{OpPeek,       8'h00, 1'b1, {8'h00, 1'b0, 1'b0, 9'd0, 9'd0}},
    '{OpPop,        8'h00, 1'b1, {8'h00, 1'b0, 1'b0, 9'd0, 9'd0}},
    '{OpRemove,     8'h05, 1'b1, {8'h00, 1'b0, 1'b1, 9'd0, 9'd0}},
    // Lowest and highest tag at the tail: 00 FF.
    '{OpInsertTail, 8'h00, 1'b1, {8'h00, 1'b1, 1'b0, 9'd1, 9'd1}},
    '{OpInsertTail, 8'hFF, 1'b1, {8'h00, 1'b1, 1'b0, 9'd2, 9'd2}},
    // A tag that is already queued is refused.
    '{OpInsertTail, 8'h00, 1'b1, {8'h00, 1'b1, 1'b1, 9'd2, 9'd2}},
    // Insert at the head: 80 00 FF.
    '{OpInsertHead, 8'h80, 1'b1, {8'h80, 1'b1, 1'b0, 9'd3, 9'd3}},
    '{OpInsertHead, 8'hFF, 1'b1, {8'h80, 1'b1, 1'b1, 9'd3, 9'd3}},
    // Spare operation codes only report the head.
    '{OpSpare5,     8'hAA, 1'b1, {8'h80, 1'b1, 1'b0, 9'd3, 9'd3}},
    '{OpSpare6,     8'h55, 1'b0, '0},
    '{OpSpare7,     8'hFF, 1'b0, '0},
    // Removal from the middle, then of the tail: 80.
    '{OpRemove,     8'h00, 1'b0, '0},
    '{OpRemove,     8'hFF, 1'b0, '0},
    '{OpRemove,     8'h00, 1'b1, {8'h80, 1'b1, 1'b1, 9'd1, 9'd3}},
    // Pop of the last tag empties the queue; the tag field is ignored.
    '{OpPop,        8'h7F, 1'b1, {8'h80, 1'b1, 1'b0, 9'd0, 9'd3}},
    // Build 03 01 02, remove the head, then pop until empty.
    '{OpInsertHead, 8'h01, 1'b0, '0},
    '{OpInsertTail, 8'h02, 1'b0, '0},
    '{OpInsertHead, 8'h03, 1'b0, '0},
    '{OpRemove,     8'h03, 1'b0, '0},
    '{OpPop,        8'hC3, 1'b0, '0},
    '{OpPop,        8'h3C, 1'b0, '0},
    '{OpPop,        8'h00, 1'b1, {8'h00, 1'b0, 1'b0, 9'd0, 9'd3}},
    // Removal of the only queued tag empties the queue.
    '{OpInsertTail, 8'hAA, 1'b0, '0},
    '{OpRemove,     8'hAA, 1'b1, {8'h00, 1'b0, 1'b0, 9'd0, 9'd3}}
  };

  logic clk;
  logic rst_n;

  dlrq_req_if req_if ();
  dlrq_rsp_if rsp_if ();

  doubly_linked_request_queue uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // Model of the list. The link stores are only read for queued tags, whose
  // links were written when they went in, so they need no reset value.
  logic [TagW-1:0]     link_next [TagCount];
  logic [TagW-1:0]     link_prev [TagCount];
  logic [TagCount-1:0] in_queue;
  logic [TagW-1:0]     q_head;
  logic [TagW-1:0]     q_tail;
  logic [CntW-1:0]     q_count;
  logic [CntW-1:0]     q_high;

  // Responses still owed by the block, oldest first.
  queue_result_t pending_results [$];

  // When set, the matching side runs back to back with no idle cycles.
  bit src_steady;
  bit sink_steady;

  int requests_sent;
  int responses_checked;
  int error_responses;
  int mismatch_count;

  // The clock runs from time zero.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Prints one mismatch line, up to a limit, and counts every one.
  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= PrintLimit) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endtask

  // Takes a queued tag out of the model list and closes the gap around it.
  function automatic void unlink_tag(input logic [TagW-1:0] t);
    logic [TagW-1:0] next_t;
    logic [TagW-1:0] prev_t;
    next_t = link_next[t];
    prev_t = link_prev[t];
    if (t == q_tail) begin
      q_tail = prev_t;
    end else begin
      link_prev[next_t] = prev_t;
    end
    if (t == q_head) begin
      q_head = next_t;
    end else begin
      link_next[prev_t] = next_t;
    end
    in_queue[t] = 1'b0;
    if (q_count != 0) begin
      q_count--;
    end
    // An empty queue parks head and tail at tag zero.
    if (q_count == 0) begin
      q_head = '0;
      q_tail = '0;
    end
  endfunction

  // Applies one accepted request to the model and returns the response that
  // the block must give for it.
  function automatic queue_result_t predict_queue(input logic [OpW-1:0] op,
                                                  input logic [TagW-1:0] tag);
    queue_result_t res;
    res = '0;
    case (op)
      OpInsertTail, OpInsertHead: begin
        if (in_queue[tag]) begin
          res.error = 1'b1;
        end else begin
          if (op == OpInsertTail) begin
            link_prev[tag] = q_tail;
            link_next[tag] = '0;
            if (q_count != 0) begin
              link_next[q_tail] = tag;
            end else begin
              q_head = tag;
            end
            q_tail = tag;
          end else begin
            link_next[tag] = q_head;
            link_prev[tag] = '0;
            if (q_count != 0) begin
              link_prev[q_head] = tag;
            end else begin
              q_tail = tag;
            end
            q_head = tag;
          end
          in_queue[tag] = 1'b1;
          q_count++;
          if (q_count > q_high) begin
            q_high = q_count;
          end
        end
      end
      OpRemove: begin
        if (!in_queue[tag]) begin
          res.error = 1'b1;
        end else begin
          unlink_tag(tag);
        end
      end
      OpPop: begin
        // A pop reports the tag it took; on an empty queue it reports none.
        if (q_count != 0) begin
          res.tag       = q_head;
          res.tag_valid = 1'b1;
          unlink_tag(q_head);
        end
      end
      default: begin
        // Peek and the spare codes leave the list alone.
      end
    endcase
    // Everything but a pop reports the head after the operation.
    if (op != OpPop && q_count != 0) begin
      res.tag       = q_head;
      res.tag_valid = 1'b1;
    end
    res.count      = q_count;
    res.high_water = q_high;
    return res;
  endfunction

  // Finds a tag that is queued (want_queued set) or free, starting at a
  // random place. The caller makes sure that such a tag exists.
  function automatic logic [TagW-1:0] pick_tag(input logic want_queued);
    logic [TagW-1:0] t;
    t = TagW'($urandom);
    for (int i = 0; i < TagCount; i++) begin
      if (in_queue[t] == want_queued) begin
        return t;
      end
      t++;
    end
    return t;
  endfunction

  // Presents one request, waits for its transfer and files the response that
  // it must cause. Valid is lowered only where an idle gap follows, at the
  // edge of the previous transfer, so it never sees two updates in one step.
  task automatic send_request(input logic [OpW-1:0]  op,
                              input logic [TagW-1:0] tag,
                              input logic            has_result,
                              input queue_result_t   known);
    int            gap;
    queue_result_t predicted;
    if ($urandom_range(0, 39) == 0) begin
      src_steady = !src_steady;
    end
    gap = src_steady ? 0 : $urandom_range(0, MaxWait);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid       <= 1'b1;
    req_if.operation   <= op;
    req_if.request_tag <= tag;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    // The model always runs so that its state follows the block; a typed
    // row only overrides what is expected for that one response.
    predicted = predict_queue(op, tag);
    pending_results.push_back(has_result ? known : predicted);
    requests_sent++;
  endtask

  // Request side: reset, directed rows, then the random mix.
  initial begin
    logic [OpW-1:0]  op;
    logic [TagW-1:0] tag;
    int              random_sent;
    int              bias;
    int              pick;
    int              ins_lim;
    int              rem_lim;
    int              pop_lim;
    int              peek_lim;
    bit              filled;

    rst_n              <= 1'b0;
    req_if.valid       <= 1'b0;
    req_if.operation   <= '0;
    req_if.request_tag <= '0;
    in_queue    = '0;
    q_head      = '0;
    q_tail      = '0;
    q_count     = '0;
    q_high      = '0;
    random_sent = 0;
    bias        = 0;
    filled      = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < $size(DirectedRows); i++) begin
      send_request(DirectedRows[i].op, DirectedRows[i].tag, DirectedRows[i].has_result,
                   DirectedRows[i].result);
    end

    // The random part is mostly legal traffic: inserts of free tags and
    // removals of queued ones, so that the list grows long and is cut at
    // every position. The mix leans toward growth, shrinkage or balance, drawn
    // at random, and a small share is refused requests and spare codes.
    while (random_sent < RandomRequests) begin
      if (!filled && random_sent >= FillPoint) begin
        // Fill every tag once, hammer the full queue with duplicates and
        // peeks, then drain it completely with pops and removals.
        while (q_count < TagCount) begin
          op = $urandom_range(0, 1) ? OpInsertHead : OpInsertTail;
          send_request(op, pick_tag(1'b0), 1'b0, '0);
          random_sent++;
        end
        repeat (8) begin
          op = $urandom_range(0, 2) == 0 ? OpPeek :
               ($urandom_range(0, 1) ? OpInsertHead : OpInsertTail);
          send_request(op, pick_tag(1'b1), 1'b0, '0);
          random_sent++;
        end
        while (q_count != 0) begin
          if ($urandom_range(0, 1) == 0) begin
            send_request(OpPop, TagW'($urandom), 1'b0, '0);
          end else begin
            send_request(OpRemove, pick_tag(1'b1), 1'b0, '0);
          end
          random_sent++;
        end
        filled = 1'b1;
      end

      if (random_sent % BiasSpan == 0) begin
        bias = $urandom_range(0, 2);
      end
      case (bias)
        0: begin  // growth
          ins_lim = 60; rem_lim = 75; pop_lim = 87; peek_lim = 93;
        end
        1: begin  // shrinkage
          ins_lim = 25; rem_lim = 55; pop_lim = 85; peek_lim = 92;
        end
        default: begin  // balance
          ins_lim = 40; rem_lim = 62; pop_lim = 82; peek_lim = 90;
        end
      endcase

      pick = $urandom_range(0, 99);
      if (pick < ins_lim) begin
        // On a full queue every tag is taken, so this becomes a duplicate.
        op  = $urandom_range(0, 1) ? OpInsertHead : OpInsertTail;
        tag = pick_tag(q_count == TagCount);
      end else if (pick < rem_lim) begin
        op  = OpRemove;
        tag = (q_count == 0) ? TagW'($urandom) : pick_tag(1'b1);
      end else if (pick < pop_lim) begin
        op  = OpPop;
        tag = TagW'($urandom);
      end else if (pick < peek_lim) begin
        op  = OpPeek;
        tag = TagW'($urandom);
      end else begin
        case ($urandom_range(0, 2))
          0: begin  // duplicate insert
            op  = $urandom_range(0, 1) ? OpInsertHead : OpInsertTail;
            tag = (q_count != 0) ? pick_tag(1'b1) : TagW'($urandom);
          end
          1: begin  // removal of a tag that is not queued, if the queue is not full
            op  = OpRemove;
            tag = (q_count < TagCount) ? pick_tag(1'b0) : TagW'($urandom);
          end
          default: begin
            op  = OpW'($urandom_range(OpSpare5, OpSpare7));
            tag = TagW'($urandom);
          end
        endcase
      end
      send_request(op, tag, 1'b0, '0);
      random_sent++;
    end

    // The last transfer happened at this edge; nothing else drives valid now.
    req_if.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Sent %0d requests (%0d directed), checked %0d responses, %0d refused.",
             requests_sent, $size(DirectedRows), responses_checked, error_responses);
    $display("Queue depth reached %0d of %0d tags; %0d mismatches.",
             q_high, TagCount, mismatch_count);
    if (mismatch_count == 0) begin
      $display("** doubly_linked_request_queue: PASSED **");
    end else begin
      $display("** doubly_linked_request_queue: FAILED **");
    end
    $finish;
  end

  // Response side: random back-pressure, and every transfer is compared
  // field by field with the oldest pending response.
  initial begin
    int            stall;
    queue_result_t got;
    queue_result_t want;

    rsp_if.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      if ($urandom_range(0, 39) == 0) begin
        sink_steady = !sink_steady;
      end
      stall = sink_steady ? 0 : $urandom_range(0, MaxWait);
      if (stall != 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk); while (rsp_if.valid !== 1'b1);
      got = {rsp_if.out_tag, rsp_if.tag_valid, rsp_if.error, rsp_if.queue_count,
             rsp_if.high_water};
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("response with none pending: tag %0h count %0d",
                                  got.tag, got.count));
      end else begin
        want = pending_results.pop_front();
        responses_checked++;
        if (want.error) begin
          error_responses++;
        end
        if (got.tag !== want.tag) begin
          report_mismatch($sformatf("response %0d out_tag %0h, expected %0h",
                                    responses_checked, got.tag, want.tag));
        end
        if (got.tag_valid !== want.tag_valid) begin
          report_mismatch($sformatf("response %0d tag_valid %0b, expected %0b",
                                    responses_checked, got.tag_valid, want.tag_valid));
        end
        if (got.error !== want.error) begin
          report_mismatch($sformatf("response %0d error %0b, expected %0b",
                                    responses_checked, got.error, want.error));
        end
        if (got.count !== want.count) begin
          report_mismatch($sformatf("response %0d queue_count %0d, expected %0d",
                                    responses_checked, got.count, want.count));
        end
        if (got.high_water !== want.high_water) begin
          report_mismatch($sformatf("response %0d high_water %0d, expected %0d",
                                    responses_checked, got.high_water, want.high_water));
        end
      end
    end
  end

  // Watchdog: a correct run with the longest gaps on both sides needs well
  // under two milliseconds, so ten means the block has hung.
  initial begin
    #10_000_000;
    $display("Watchdog expired with %0d responses pending.", pending_results.size());
    $display("** doubly_linked_request_queue: FAILED **");
    $finish;
  end

endmodule
